[design/ffa_pkg.sv]
// Package: transaction types, operation and status codes for the first-fit allocator.
`default_nettype none
package ffa_pkg;

  localparam logic [2:0] FLAG_START = 3'h1;
  localparam logic [2:0] FLAG_END   = 3'h2;
  localparam logic [2:0] FLAG_USED  = 3'h4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_INIT  = 2'd2;

  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
  localparam logic [1:0] REG_POOL_BASE   = 2'd2;

  localparam logic [15:0] SIZE_RESET  = 16'd128;
  localparam logic [10:0] COUNT_RESET = 11'd1024;
  localparam logic [25:0] BYTES_MAX   = 26'h3FFFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] request_bytes;
    logic [31:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_address;
    logic [25:0] free_bytes;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [23:0] req;
    logic [31:0] addr;
  } cmd_t;

endpackage
`default_nettype wire

[design/ffa_front.sv]
// Front end: decodes input transactions and holds them in a two-entry queue.
`default_nettype none
module ffa_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ffa_pkg::in_item_t in_item,
  input  wire logic             hold,
  output logic                  q_valid,
  output ffa_pkg::cmd_t         q_cmd,
  input  wire logic             q_pop
);
  import ffa_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    dec.req  = in_item.request_bytes;
    dec.addr = in_item.release_address;
    case (in_item.func)
      FN_ALLOC: dec.op = OP_ALLOC;
      FN_FREE:  dec.op = OP_FREE;
      FN_INIT:  dec.op = OP_INIT;
      default:  dec.op = OP_BAD;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2) | hold;
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop & q_valid;
  assign q_cmd    = slot_r[rp_r];

  assign wp_nxt  = push ? ~wp_r : wp_r;
  assign rp_nxt  = pop ? ~rp_r : rp_r;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= dec;
    end
  end

endmodule
`default_nettype wire

[design/ffa_back.sv]
// Back end: flag table memory, scan/mark/free/count sequencer and result register.
`default_nettype none
module ffa_back #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [15:0]        block_size,
  input  wire logic [10:0]        block_count,
  input  wire logic [31:0]        pool_base,
  input  wire logic               q_valid,
  input  wire ffa_pkg::cmd_t      q_cmd,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ffa_pkg::out_item_t      out_item
);
  import ffa_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = IW + 1;
  localparam int AW = CW + 16;
  localparam int PW = CW + 16;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ALLOC, S_MARK, S_FIND, S_FREE, S_COUNT, S_MUL, S_RESP
  } state_t;

  logic [2:0] mem [MAX_BLOCKS];
  logic [2:0] rd_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [2:0]    mem_wd;

  state_t        state_r, state_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [24:0]   runb_r, runb_nxt;
  logic [IW-1:0] start_r, start_nxt, end_r, end_nxt, blk_r, blk_nxt;
  logic [31:0]   sta_r, sta_nxt, grant_r, grant_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          init_r, init_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic          ov_r, ov_nxt;
  out_item_t     oi_r, oi_nxt;

  logic [15:0]   esize;
  logic [CW-1:0] n_eff;
  logic          last;
  logic [24:0]   runb_add;
  logic [25:0]   bytes_sat;

  assign esize = (block_size == 16'd0) ? 16'd1 : block_size;
  assign n_eff = (32'(block_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(block_count);
  assign last  = ({1'b0, pidx_r} == (n_eff - CW'(1)));
  assign runb_add  = runb_r + 25'(esize);
  assign bytes_sat = (34'(prod_r) > 34'(BYTES_MAX)) ? BYTES_MAX : 26'(prod_r);

  assign clearing  = (state_r == S_CLR);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  always_comb begin
    state_nxt  = state_r;
    ia_nxt     = ia_r;
    pv_nxt     = 1'b0;
    pidx_nxt   = pidx_r;
    acc_nxt    = acc_r;
    runb_nxt   = runb_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    blk_nxt    = blk_r;
    sta_nxt    = sta_r;
    grant_nxt  = grant_r;
    d_nxt      = d_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    status_nxt = status_r;
    init_nxt   = init_r;
    cmd_nxt    = cmd_r;
    ov_nxt     = ov_r & out_stall;
    oi_nxt     = oi_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = ia_r[IW-1:0];
    mem_wd     = 3'd0;

    // streaming reads: issue ia, process the registered data in the cycle after
    if (state_r == S_ALLOC || state_r == S_FREE || state_r == S_COUNT) begin
      ia_nxt   = ia_r + CW'(1);
      pv_nxt   = (ia_r < n_eff);
      pidx_nxt = ia_r[IW-1:0];
    end

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wd = (ia_r == '0) ? (FLAG_START | FLAG_END | FLAG_USED) : 3'd0;
        ia_nxt = ia_r + CW'(1);
        if (ia_r == CW'(MAX_BLOCKS - 1)) begin
          ia_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = init_r ? S_COUNT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          grant_nxt = '0;
          ia_nxt    = '0;
          acc_nxt   = '0;
          runb_nxt  = '0;
          cnt_nxt   = '0;
          init_nxt  = 1'b0;
          case (q_cmd.op)
            OP_ALLOC: begin
              status_nxt = ST_NOSPACE;
              state_nxt  = (n_eff == '0) ? S_COUNT : S_ALLOC;
            end
            OP_FREE: begin
              status_nxt = ST_IGNORED;
              d_nxt      = q_cmd.addr - pool_base;
              state_nxt  = (n_eff == '0 || q_cmd.addr < pool_base) ? S_COUNT : S_FIND;
            end
            OP_INIT: begin
              status_nxt = ST_DONE;
              init_nxt   = 1'b1;
              state_nxt  = S_CLR;
            end
            default: begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_COUNT;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (pv_r) begin
          acc_nxt = acc_r + AW'(esize);
          if ((rd_r & FLAG_USED) == 3'd0) begin
            if (runb_r == '0) begin
              start_nxt = pidx_r;
              sta_nxt   = pool_base + 32'(acc_r);
            end
            runb_nxt = runb_add;
            if ({1'b0, runb_add} > {2'b0, cmd_r.req}) begin
              end_nxt   = pidx_r;
              ia_nxt    = (runb_r == '0) ? {1'b0, pidx_r} : {1'b0, start_r};
              state_nxt = S_MARK;
            end else if (last) begin
              ia_nxt    = '0;
              state_nxt = S_COUNT;
            end
          end else begin
            runb_nxt = '0;
            if (last) begin
              ia_nxt    = '0;
              state_nxt = S_COUNT;
            end
          end
          if (state_nxt != S_ALLOC) begin
            pv_nxt = 1'b0;
          end
        end
      end
      S_MARK: begin
        mem_we = 1'b1;
        mem_wd = FLAG_USED
               | ((ia_r[IW-1:0] == start_r) ? FLAG_START : 3'd0)
               | ((ia_r[IW-1:0] == end_r) ? FLAG_END : 3'd0);
        ia_nxt = ia_r + CW'(1);
        if (ia_r[IW-1:0] == end_r) begin
          status_nxt = ST_DONE;
          grant_nxt  = sta_r;
          ia_nxt     = '0;
          state_nxt  = S_COUNT;
        end
      end
      S_FIND: begin
        // walk block offsets until the one holding the address
        if ({2'b0, d_r} < (34'(acc_r) + 34'(esize))) begin
          blk_nxt   = ia_r[IW-1:0];
          state_nxt = S_FREE;
        end else if (ia_r == (n_eff - CW'(1))) begin
          ia_nxt    = '0;
          state_nxt = S_COUNT;
        end else begin
          ia_nxt  = ia_r + CW'(1);
          acc_nxt = acc_r + AW'(esize);
        end
      end
      S_FREE: begin
        if (pv_r) begin
          if (pidx_r == blk_r && (rd_r & FLAG_START) == 3'd0) begin
            ia_nxt    = '0;
            pv_nxt    = 1'b0;
            state_nxt = S_COUNT;
          end else begin
            mem_we = 1'b1;
            mem_wa = pidx_r;
            mem_wd = 3'd0;
            if ((rd_r & FLAG_END) != 3'd0 || last) begin
              status_nxt = ST_DONE;
              ia_nxt     = '0;
              pv_nxt     = 1'b0;
              state_nxt  = S_COUNT;
            end
          end
        end
      end
      S_COUNT: begin
        if (n_eff == '0) begin
          pv_nxt    = 1'b0;
          state_nxt = S_MUL;
        end else if (pv_r) begin
          if (rd_r == 3'd0) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (last) begin
            pv_nxt    = 1'b0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(cnt_r) * PW'(esize);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || !out_stall) begin
          ov_nxt               = 1'b1;
          oi_nxt.status        = status_r;
          oi_nxt.grant_address = grant_r;
          oi_nxt.free_bytes    = bytes_sat;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[ia_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ia_r    <= '0;
      pv_r    <= 1'b0;
      init_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ia_r    <= ia_nxt;
      pv_r    <= pv_nxt;
      init_r  <= init_nxt;
      ov_r    <= ov_nxt;
    end
    pidx_r   <= pidx_nxt;
    acc_r    <= acc_nxt;
    runb_r   <= runb_nxt;
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    blk_r    <= blk_nxt;
    sta_r    <= sta_nxt;
    grant_r  <= grant_nxt;
    d_r      <= d_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    status_r <= status_nxt;
    cmd_r    <= cmd_nxt;
    oi_r     <= oi_nxt;
  end

endmodule
`default_nettype wire

[design/first_fit_block_allocator.sv]
// Top level: first-fit block allocator with config registers, front queue and back sequencer.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_item (func, request_bytes, release_address)
//  out_    | output    | out_valid/out_stall| out_item (status, grant_address, free_bytes)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// Each transaction walks the single-port flag table one entry per cycle: allocate scans for
//   a free run and marks it, free walks to the block and clears its run, init clears the
//   table; each then counts the free entries over the effective block count.
// Reset: a clearing pass writes every flag table entry; in_stall is high meanwhile.
// The two-entry queue keeps accepting, until full, while the back end works or a result is stalled.
`default_nettype none
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ffa_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ffa_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import ffa_pkg::*;

  logic [15:0] block_size_r;
  logic [10:0] block_count_r;
  logic [31:0] pool_base_r;
  logic        q_valid, q_pop, clearing;
  cmd_t        q_cmd;

  assign cfg_ready = 1'b1;

  // config writes are expected only while no transaction is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= SIZE_RESET;
      block_count_r <= COUNT_RESET;
      pool_base_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_SIZE:  block_size_r  <= cfg_wdata[15:0];
        REG_BLOCK_COUNT: block_count_r <= cfg_wdata[10:0];
        REG_POOL_BASE:   pool_base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: decode + queue
  ffa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .hold     (clearing),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // back: table walk and result register
  ffa_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .block_size  (block_size_r),
    .block_count (block_count_r),
    .pool_base   (pool_base_r),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

[tb/ffa_scoreboard.sv]
// Scoreboard for the first-fit allocator: flag-table predictor and expected-result queue.
import ffa_pkg::*;

class ffa_scoreboard;
  logic [2:0]  flag_tab [1024];
  logic [15:0] blk_size;
  logic [10:0] blk_count;
  logic [31:0] pool_base;
  out_item_t   expected_q [$];
  logic [31:0] live_grants [$];
  int          errors;

  function void reset_state();
    blk_size  = SIZE_RESET;
    blk_count = COUNT_RESET;
    pool_base = 32'd0;
    clear_flags();
    expected_q.delete();
    live_grants.delete();
    errors = 0;
  endfunction

  function void clear_flags();
    foreach (flag_tab[i]) flag_tab[i] = 3'd0;
    flag_tab[0] = FLAG_START | FLAG_END | FLAG_USED;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_BLOCK_SIZE:  blk_size  = data[15:0];
      REG_BLOCK_COUNT: blk_count = data[10:0];
      REG_POOL_BASE:   pool_base = data;
      default: ;
    endcase
  endfunction

  function logic [31:0] eff_size();
    return (blk_size == 16'd0) ? 32'd1 : {16'd0, blk_size};
  endfunction

  function int eff_count();
    return (blk_count > 11'd1024) ? 1024 : int'(blk_count);
  endfunction

  // Predict the result of one accepted request and queue it.
  function void note_request(in_item_t it);
    out_item_t   res;
    logic [31:0] sz, need, blk;
    logic [63:0] pool_end, bytes;
    int          n, run, start, i, unused;
    bit          found, last;
    sz  = eff_size();
    n   = eff_count();
    res = '0;
    res.status = ST_IGNORED;
    case (op_t'(it.func))
      OP_ALLOC: begin
        need  = {8'd0, it.request_bytes} / sz + 32'd1;
        run   = 0;
        start = 0;
        found = 0;
        for (i = 0; i < n && !found; i++) begin
          if ((flag_tab[i] & FLAG_USED) == 3'd0) begin
            if (run == 0) start = i;
            run++;
            if (run >= need) found = 1;
          end else begin
            run = 0;
          end
        end
        if (!found) begin
          res.status = ST_NOSPACE;
        end else begin
          for (i = start; i < start + int'(need); i++) flag_tab[i] = FLAG_USED;
          flag_tab[start] |= FLAG_START;
          flag_tab[start + int'(need) - 1] |= FLAG_END;
          res.status        = ST_DONE;
          res.grant_address = pool_base + 32'(start) * sz;
          live_grants.push_back(res.grant_address);
        end
      end
      OP_FREE: begin
        pool_end = {32'd0, pool_base} + 64'(n) * {32'd0, sz};
        if (it.release_address >= pool_base && {32'd0, it.release_address} < pool_end) begin
          blk = (it.release_address - pool_base) / sz;
          if (blk < n && (flag_tab[blk] & FLAG_START) != 3'd0) begin
            res.status = ST_DONE;
            for (i = int'(blk); i < n; i++) begin
              last = (flag_tab[i] & FLAG_END) != 3'd0;
              flag_tab[i] = 3'd0;
              if (last) break;
            end
          end
        end
      end
      OP_INIT: begin
        clear_flags();
        res.status = ST_DONE;
      end
      default: ;
    endcase
    unused = 0;
    for (i = 0; i < n; i++) if (flag_tab[i] == 3'd0) unused++;
    bytes = 64'(unused) * {32'd0, sz};
    if (bytes > {38'd0, BYTES_MAX}) bytes = {38'd0, BYTES_MAX};
    res.free_bytes = bytes[25:0];
    expected_q.push_back(res);
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp_res;
    if (expected_q.size() == 0) begin
      $error("unexpected result transaction: status %0d grant %h free %0d",
             got.status, got.grant_address, got.free_bytes);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (got.status !== exp_res.status) begin
      $error("status: expected %0d actual %0d", exp_res.status, got.status);
      errors++;
    end
    if (got.grant_address !== exp_res.grant_address) begin
      $error("grant_address: expected %h actual %h", exp_res.grant_address,
             got.grant_address);
      errors++;
    end
    if (got.free_bytes !== exp_res.free_bytes) begin
      $error("free_bytes: expected %0d actual %0d", exp_res.free_bytes, got.free_bytes);
      errors++;
    end
  endfunction
endclass

[tb/tb_top.sv]
// Testbench top: drives the first-fit allocator with directed and random transactions.
import ffa_pkg::*;

module tb_top;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES   = 3200;  // init plus a full scan and walk

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_wdata = 32'd0;

  ffa_scoreboard alloc_sb;
  int  rx_gap = 0;
  int  rx_hold = 0;      // long receiver hold-off, counted down here
  bit  rx_busy_only = 0; // stretches with no receiver idling
  bit  tx_busy_only = 0;
  int  idle_cycles = 0;

  always #2 clk = ~clk;

  first_fit_block_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Receiver: stall pattern updated on the falling edge.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap    <= rx_gap - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result check on the rising edge; a fresh stall count is drawn per result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      alloc_sb.check_result(out_item);
      rx_gap = rx_busy_only ? 0 : $urandom_range(0, 5);
    end
  end

  // Watchdog: cycles without any accepted transaction on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_busy_only ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    alloc_sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (alloc_sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index = idx;
    cfg_wdata = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    alloc_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [31:0] size, logic [31:0] count, logic [31:0] base);
    wait_drained();
    write_reg(REG_BLOCK_SIZE, size);
    write_reg(REG_BLOCK_COUNT, count);
    write_reg(REG_POOL_BASE, base);
  endtask

  function automatic in_item_t mk_item(op_t op, logic [23:0] req, logic [31:0] addr);
    in_item_t it;
    it.func            = op;
    it.request_bytes   = req;
    it.release_address = addr;
    return it;
  endfunction

  // Mostly well-formed traffic: sized allocations and frees of live grants,
  // with some noise (random addresses, pool edges, init, unknown func).
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [31:0] sz, span;
    int          r, k;
    sz = alloc_sb.eff_size();
    it = mk_item(OP_ALLOC, 24'($urandom), $urandom);
    r  = $urandom_range(0, 99);
    if (r < 45) begin
      span = sz * 6;
      if (span > 32'hFFFFFF) span = 32'hFFFFFF;
      it.request_bytes = 24'($urandom_range(0, span));
    end else if (r < 50) begin
      it.func = OP_ALLOC;
    end else if (r < 85 && alloc_sb.live_grants.size() > 0) begin
      k = $urandom_range(0, alloc_sb.live_grants.size() - 1);
      it.func = OP_FREE;
      it.release_address = alloc_sb.live_grants[k];
      // Sometimes an unaligned address inside the start block.
      if ($urandom_range(0, 3) == 0) it.release_address += $urandom_range(0, sz - 1);
      alloc_sb.live_grants.delete(k);
    end else if (r < 93) begin
      it.func = OP_FREE;
      case ($urandom_range(0, 3))
        0: ;
        1: it.release_address = alloc_sb.pool_base + sz * alloc_sb.eff_count();
        2: it.release_address = alloc_sb.pool_base - 32'($urandom_range(1, 8));
        default: it.release_address = alloc_sb.pool_base
                                      + sz * $urandom_range(0, alloc_sb.eff_count());
      endcase
    end else if (r < 96) begin
      it.func = OP_INIT;
    end else begin
      it.func = OP_BAD;
    end
    return it;
  endfunction

  task automatic random_run(int count);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) tx_busy_only = ~tx_busy_only;
      if ($urandom_range(0, 39) == 0) rx_busy_only = ~rx_busy_only;
      send_item(random_item());
    end
  endtask

  initial begin
    alloc_sb = new();
    alloc_sb.reset_state();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset configuration: 128-byte blocks, 1024 entries, base 0.
    send_item(mk_item(OP_ALLOC, 24'd0, 32'd0));           // one block, entry 1
    send_item(mk_item(OP_ALLOC, 24'd127, 32'd0));         // still one block
    send_item(mk_item(OP_ALLOC, 24'd128, 32'd0));         // two blocks
    send_item(mk_item(OP_ALLOC, 24'hFFFFFF, 32'd0));      // no space
    send_item(mk_item(OP_FREE, 24'd0, 32'd200));          // unaligned, start of entry 1
    send_item(mk_item(OP_FREE, 24'd0, 32'd512));          // not a start entry
    send_item(mk_item(OP_FREE, 24'd0, 32'd131072));       // pool end
    send_item(mk_item(OP_FREE, 24'd0, 32'hFFFFFFFF));     // far outside
    send_item(mk_item(OP_FREE, 24'd0, 32'd0));            // reserved entry 0
    send_item(mk_item(OP_ALLOC, 24'd200, 32'd0));         // reuses entry 0
    send_item(mk_item(OP_BAD, 24'hFFFFFF, 32'hFFFFFFFF)); // unknown func
    send_item(mk_item(OP_INIT, 24'd0, 32'd0));
    send_item(mk_item(OP_ALLOC, 24'd1000, 32'd0));

    // Single entry near the top of the address space: allocate finds no space.
    configure(32'd1, 32'd1, 32'hFFFFFFF0);
    send_item(mk_item(OP_ALLOC, 24'd0, 32'd0));
    send_item(mk_item(OP_FREE, 24'd0, 32'hFFFFFFEF));     // below base
    send_item(mk_item(OP_FREE, 24'd0, 32'hFFFFFFF0));     // frees entry 0
    send_item(mk_item(OP_ALLOC, 24'd0, 32'd0));
    random_run(15);

    // Largest blocks, oversized count: the count is capped at 1024 entries.
    configure(32'd65535, 32'd2047, 32'h12345678);
    send_item(mk_item(OP_INIT, 24'd0, 32'd0));
    random_run(25);

    // Zero size and zero count.
    configure(32'd0, 32'd0, 32'd0);
    send_item(mk_item(OP_ALLOC, 24'd0, 32'd0));
    send_item(mk_item(OP_FREE, 24'd0, 32'd0));
    configure(32'd0, 32'd50, 32'd0);
    random_run(30);

    // Main random phase with small pool; one long receiver hold-off.
    configure(32'd16, 32'd64, $urandom);
    random_run(150);
    tx_busy_only = 1;
    rx_hold = 300;
    random_run(20);
    tx_busy_only = 0;
    random_run(200);

    // Shrink the count under existing runs so some walks hit the last entry.
    configure(32'd100, 32'd40, 32'h80000000);
    random_run(100);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (alloc_sb.errors == 0 && alloc_sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[first_fit_block_allocator.f]
design/ffa_pkg.sv
design/ffa_front.sv
design/ffa_back.sv
design/first_fit_block_allocator.sv
tb/ffa_scoreboard.sv
tb/tb_top.sv
